// ----- design/leg_jacobian_transpose_torque_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the leg Jacobian-transpose torque block.
// ----------------------------------------------------------------------------
`ifndef LEG_JACOBIAN_TRANSPOSE_TORQUE_ASSERT_SVH
`define LEG_JACOBIAN_TRANSPOSE_TORQUE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define LJT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// The consequent must hold in the same cycle as the antecedent.
`define LJT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`endif

// ----- design/ljt_pkg.sv -----
// ----------------------------------------------------------------------------
// ljt_pkg
// Types, constants and helper functions of the leg Jacobian-transpose unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ljt_pkg;

    // Pipeline depth and number of series terms after the first.
    localparam int NSTG  = 29;
    localparam int NTERM = 6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HIP   = 2'd0;
    localparam logic [1:0] CFG_THIGH = 2'd1;
    localparam logic [1:0] CFG_CALF  = 2'd2;

    // Register reset values, unsigned Q0.16 metres.
    localparam logic [15:0] HIP_RST   = 16'd5243;
    localparam logic [15:0] THIGH_RST = 16'd13959;
    localparam logic [15:0] CALF_RST  = 16'd13959;

    // Angle reduction constants in Q30.
    localparam logic signed [33:0] QPI   = 34'sd843314856;
    localparam logic signed [33:0] HPI   = 34'sd1686629713;
    localparam logic signed [33:0] HPI2  = 34'sd3373259426;
    localparam logic signed [33:0] HPI3  = 34'sd5059889139;
    localparam logic signed [33:0] THR1  = 34'sd843314856;
    localparam logic signed [33:0] THR2  = 34'sd2529944569;
    localparam logic signed [33:0] THR3  = 34'sd4216574282;
    localparam logic signed [31:0] ONE30 = 32'sd1073741824;

    // Series divisors and their reciprocals scaled by 2^32.
    localparam logic [7:0] D_SIN [NTERM] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [7:0] D_COS [NTERM] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
    localparam logic [31:0] R_SIN [NTERM] = '{
        32'(64'd4294967296 / 64'd6),   32'(64'd4294967296 / 64'd20),
        32'(64'd4294967296 / 64'd42),  32'(64'd4294967296 / 64'd72),
        32'(64'd4294967296 / 64'd110), 32'(64'd4294967296 / 64'd156)};
    localparam logic [31:0] R_COS [NTERM] = '{
        32'(64'd4294967296 / 64'd2),   32'(64'd4294967296 / 64'd12),
        32'(64'd4294967296 / 64'd30),  32'(64'd4294967296 / 64'd56),
        32'(64'd4294967296 / 64'd90),  32'(64'd4294967296 / 64'd132)};

    // Working state of one angle through the sine and cosine series.
    typedef struct packed {
        logic [30:0]        x2;
        logic [1:0]         quad;
        logic signed [31:0] s;
        logic signed [31:0] c;
        logic signed [31:0] ts;
        logic signed [31:0] tc;
    } t_trig;

    // Per-item data carried alongside the pipeline.
    typedef struct packed {
        logic               neg;
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [23:0] fz;
    } t_side;

    // Signed shift right by k with truncation toward zero.
    function automatic logic signed [63:0] f_trunc(input logic signed [63:0] x,
                                                   input int unsigned k);
        logic signed [63:0] m;
        m = -x;
        return x[63] ? -(m >>> k) : (x >>> k);
    endfunction

    // Saturate to a 28-bit signed field.
    function automatic logic [27:0] f_sat28(input logic signed [63:0] x);
        if (x > 64'sd134217727) return 28'h7FFFFFF;
        else if (x < -64'sd134217728) return 28'h8000000;
        else return x[27:0];
    endfunction

    // Saturate to an 18-bit signed field.
    function automatic logic [17:0] f_sat18(input logic signed [63:0] x);
        if (x > 64'sd131071) return 18'h1FFFF;
        else if (x < -64'sd131072) return 18'h20000;
        else return x[17:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/leg_jacobian_transpose_torque.sv -----
// Throughput: one leg per cycle unless the output stalls; every step is a
// register stage of its own, the longest path being one 32 by 32 multiply
// or one wide add and compare. A stalled output holds the whole pipeline;
// nothing is lost or repeated. Reset (synchronous, active low) clears the
// valid bits and loads the link lengths with their default values.
`default_nettype none
`include "leg_jacobian_transpose_torque_assert.svh"

// ----------------------------------------------------------------------------
// leg_jacobian_transpose_torque
// Pipelined joint-torque and foot-position unit for a three-joint leg.
// ----------------------------------------------------------------------------
module leg_jacobian_transpose_torque (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // hip_angle, thigh_angle, calf_angle, force_x, force_y, force_z
    input  wire logic [119:0] s_axis_tdata,
    // leg_index
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hip_torque, thigh_torque, calf_torque, foot_x, foot_y, foot_z, zero pad
    output logic [143:0]      m_axis_tdata
);
    import ljt_pkg::*;

    logic [15:0]     r_hip_len, r_thigh_len, r_calf_len;
    logic [NSTG-1:0] r_vld;
    logic            w_adv;
    t_side           r_sd [NSTG-2];

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hip_len   <= HIP_RST;
            r_thigh_len <= THIGH_RST;
            r_calf_len  <= CALF_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HIP)   r_hip_len   <= i_cfg_data;
            if (i_cfg_index == CFG_THIGH) r_thigh_len <= i_cfg_data;
            if (i_cfg_index == CFG_CALF)  r_calf_len  <= i_cfg_data;
        end
    end

    // Pipeline advance and valid bits.
    assign w_adv         = !r_vld[NSTG-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // Side data travels with the item.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= {!s_axis_tuser[0], s_axis_tdata[71:48], s_axis_tdata[95:72],
                        s_axis_tdata[119:96]};
            for (int i = 1; i < NSTG - 2; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    // Stage 0: reduce each angle into [-pi/4, pi/4] by quarter turns.
    logic signed [31:0] r_rd  [3];
    logic [1:0]         r_qd0 [3];
    t_trig              r_tin [3];

    for (genvar a = 0; a < 3; a++) begin : g_red
        logic signed [33:0] w_r, w_red;
        logic [1:0]         w_q;
        assign w_r = {{2{s_axis_tdata[16*a+15]}}, s_axis_tdata[16*a +: 15], 17'b0};
        always_comb begin
            priority if (w_r > THR3) begin
                w_q = 2'd3; w_red = w_r - HPI3;
            end else if (w_r > THR2) begin
                w_q = 2'd2; w_red = w_r - HPI2;
            end else if (w_r > THR1) begin
                w_q = 2'd1; w_red = w_r - HPI;
            end else if (w_r < -THR3) begin
                w_q = 2'd1; w_red = w_r + HPI3;
            end else if (w_r < -THR2) begin
                w_q = 2'd2; w_red = w_r + HPI2;
            end else if (w_r < -THR1) begin
                w_q = 2'd3; w_red = w_r + HPI;
            end else begin
                w_q = 2'd0; w_red = w_r;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rd[a]  <= w_red[31:0];
                r_qd0[a] <= w_q;
            end
        end

        // Stage 1: square the reduced angle and seed both series.
        logic signed [63:0] w_sq;
        assign w_sq = 64'(r_rd[a]) * 64'(r_rd[a]);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                // Fields in order: x2, quad, s, c, ts, tc.
                r_tin[a] <= {w_sq[60:30], r_qd0[a], r_rd[a], ONE30, r_rd[a], ONE30};
            end
        end
    end

    // Stages 2 to 19: six series steps of three stages each.
    t_trig       r_trp [NTERM][3];
    t_trig       r_trm [NTERM][3];
    t_trig       r_trc [NTERM][3];
    logic [30:0] r_ps  [NTERM][3];
    logic [30:0] r_pc  [NTERM][3];
    logic [30:0] r_ps2 [NTERM][3];
    logic [30:0] r_pc2 [NTERM][3];
    logic [30:0] r_q0s [NTERM][3];
    logic [30:0] r_q0c [NTERM][3];

    for (genvar k = 0; k < NTERM; k++) begin : g_term
        for (genvar a = 0; a < 3; a++) begin : g_ang
            t_trig              w_src;
            t_trig              w_nxt;
            logic [30:0]        w_ms, w_mc, w_qs, w_qc;
            logic [61:0]        w_pps, w_ppc;
            logic [62:0]        w_mps, w_mpc;
            logic [38:0]        w_rs, w_rc;
            logic signed [31:0] w_ns, w_nc;

            if (k == 0) begin : g_first
                assign w_src = r_tin[a];
            end else begin : g_next
                assign w_src = r_trc[k-1][a];
            end

            // Term magnitude times x squared.
            assign w_ms  = w_src.ts[31] ? 31'(-w_src.ts) : w_src.ts[30:0];
            assign w_mc  = w_src.tc[31] ? 31'(-w_src.tc) : w_src.tc[30:0];
            assign w_pps = 62'(w_ms) * 62'(w_src.x2);
            assign w_ppc = 62'(w_mc) * 62'(w_src.x2);

            // Reciprocal estimate of the quotient.
            assign w_mps = 63'(r_ps[k][a]) * 63'(R_SIN[k]);
            assign w_mpc = 63'(r_pc[k][a]) * 63'(R_COS[k]);

            // Remainder check corrects the estimate by at most one.
            assign w_rs = 39'(r_ps2[k][a]) - 39'(r_q0s[k][a]) * 39'(D_SIN[k]);
            assign w_rc = 39'(r_pc2[k][a]) - 39'(r_q0c[k][a]) * 39'(D_COS[k]);
            assign w_qs = r_q0s[k][a] + 31'(w_rs >= 39'(D_SIN[k]));
            assign w_qc = r_q0c[k][a] + 31'(w_rc >= 39'(D_COS[k]));
            assign w_ns = r_trm[k][a].ts[31] ? $signed({1'b0, w_qs})
                                             : -$signed({1'b0, w_qs});
            assign w_nc = r_trm[k][a].tc[31] ? $signed({1'b0, w_qc})
                                             : -$signed({1'b0, w_qc});

            // Next working state with the new terms added in.
            always_comb begin
                w_nxt    = r_trm[k][a];
                w_nxt.ts = w_ns;
                w_nxt.tc = w_nc;
                w_nxt.s  = r_trm[k][a].s + w_ns;
                w_nxt.c  = r_trm[k][a].c + w_nc;
            end

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_trp[k][a] <= w_src;
                    r_ps[k][a]  <= w_pps[60:30];
                    r_pc[k][a]  <= w_ppc[60:30];
                    r_trm[k][a] <= r_trp[k][a];
                    r_ps2[k][a] <= r_ps[k][a];
                    r_pc2[k][a] <= r_pc[k][a];
                    r_q0s[k][a] <= w_mps[62:32];
                    r_q0c[k][a] <= w_mpc[62:32];
                    r_trc[k][a] <= w_nxt;
                end
            end
        end
    end

    // Stage 20: rotate by the quadrant count.
    logic signed [31:0] r_sn [3];
    logic signed [31:0] r_cs [3];

    for (genvar a = 0; a < 3; a++) begin : g_rot
        t_trig w_t;
        assign w_t = r_trc[NTERM-1][a];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                unique case (w_t.quad)
                    2'd0: begin r_sn[a] <= w_t.s;  r_cs[a] <= w_t.c;  end
                    2'd1: begin r_sn[a] <= w_t.c;  r_cs[a] <= -w_t.s; end
                    2'd2: begin r_sn[a] <= -w_t.s; r_cs[a] <= -w_t.c; end
                    default: begin r_sn[a] <= -w_t.c; r_cs[a] <= w_t.s; end
                endcase
            end
        end
    end

    // Stages 21 and 22: summed thigh and calf angle terms.
    logic signed [63:0] r_pcc, r_pss, r_psc, r_pcs;
    logic signed [31:0] r_s1a, r_c1a, r_s2a, r_c2a;
    logic signed [31:0] r_c23, r_s23, r_s1b, r_c1b, r_s2b, r_c2b;
    logic signed [63:0] w_c23, w_s23;

    assign w_c23 = f_trunc(r_pcc - r_pss, 30);
    assign w_s23 = f_trunc(r_psc + r_pcs, 30);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pcc <= 64'(r_cs[1]) * 64'(r_cs[2]);
            r_pss <= 64'(r_sn[1]) * 64'(r_sn[2]);
            r_psc <= 64'(r_sn[1]) * 64'(r_cs[2]);
            r_pcs <= 64'(r_cs[1]) * 64'(r_sn[2]);
            r_s1a <= r_sn[0];
            r_c1a <= r_cs[0];
            r_s2a <= r_sn[1];
            r_c2a <= r_cs[1];
            r_c23 <= w_c23[31:0];
            r_s23 <= w_s23[31:0];
            r_s1b <= r_s1a;
            r_c1b <= r_c1a;
            r_s2b <= r_s2a;
            r_c2b <= r_c2a;
        end
    end

    // Stages 23 and 24: link-length weighted terms A, B, C and D.
    logic signed [16:0] w_l2, w_l3;
    logic signed [63:0] r_pl2c2, r_pl3c23, r_pl2s2, r_pl3s23;
    logic signed [31:0] r_s1c, r_c1c;
    logic signed [63:0] w_a, w_b, w_c, w_d;
    logic signed [33:0] r_a, r_b, r_c, r_d;
    logic signed [31:0] r_s1d, r_c1d;

    assign w_l2 = $signed({1'b0, r_thigh_len});
    assign w_l3 = $signed({1'b0, r_calf_len});
    assign w_a  = f_trunc(r_pl2c2 + r_pl3c23, 16);
    assign w_b  = f_trunc(r_pl2s2 + r_pl3s23, 16);
    assign w_c  = f_trunc(r_pl3c23, 16);
    assign w_d  = f_trunc(r_pl3s23, 16);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pl2c2  <= 64'(w_l2) * 64'(r_c2b);
            r_pl3c23 <= 64'(w_l3) * 64'(r_c23);
            r_pl2s2  <= 64'(w_l2) * 64'(r_s2b);
            r_pl3s23 <= 64'(w_l3) * 64'(r_s23);
            r_s1c    <= r_s1b;
            r_c1c    <= r_c1b;
            r_a      <= w_a[33:0];
            r_b      <= w_b[33:0];
            r_c      <= w_c[33:0];
            r_d      <= w_d[33:0];
            r_s1d    <= r_s1c;
            r_c1d    <= r_c1c;
        end
    end

    // Stages 25 and 26: Jacobian entries and foot position.
    logic signed [31:0] w_h;
    logic signed [63:0] r_hs1, r_ac1, r_hc1, r_as1, r_bs1, r_bc1, r_ds1, r_dc1;
    logic signed [33:0] r_ae, r_be, r_ce;
    logic signed [63:0] w_ths1, w_tac1, w_thc1, w_tas1, w_tbs1, w_tbc1, w_tds1, w_tdc1;
    logic signed [34:0] r_j10, r_j20, r_j01, r_j11, r_j21, r_j02, r_j12, r_j22;
    logic signed [34:0] r_px, r_pz;

    assign w_h    = r_sd[24].neg ? -$signed({2'b0, r_hip_len, 14'b0})
                                 : $signed({2'b0, r_hip_len, 14'b0});
    assign w_ths1 = f_trunc(r_hs1, 30);
    assign w_tac1 = f_trunc(r_ac1, 30);
    assign w_thc1 = f_trunc(r_hc1, 30);
    assign w_tas1 = f_trunc(r_as1, 30);
    assign w_tbs1 = f_trunc(r_bs1, 30);
    assign w_tbc1 = f_trunc(r_bc1, 30);
    assign w_tds1 = f_trunc(r_ds1, 30);
    assign w_tdc1 = f_trunc(r_dc1, 30);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hs1 <= 64'(w_h) * 64'(r_s1d);
            r_ac1 <= 64'(r_a) * 64'(r_c1d);
            r_hc1 <= 64'(w_h) * 64'(r_c1d);
            r_as1 <= 64'(r_a) * 64'(r_s1d);
            r_bs1 <= 64'(r_b) * 64'(r_s1d);
            r_bc1 <= 64'(r_b) * 64'(r_c1d);
            r_ds1 <= 64'(r_d) * 64'(r_s1d);
            r_dc1 <= 64'(r_d) * 64'(r_c1d);
            r_ae  <= r_a;
            r_be  <= r_b;
            r_ce  <= r_c;
            r_j10 <= 35'(w_tac1 - w_ths1);
            r_j20 <= 35'(w_thc1 + w_tas1);
            r_j01 <= -35'(r_ae);
            r_j11 <= -35'(w_tbs1);
            r_j21 <= 35'(w_tbc1);
            r_j02 <= -35'(r_ce);
            r_j12 <= -35'(w_tds1);
            r_j22 <= 35'(w_tdc1);
            r_px  <= -35'(r_be);
            r_pz  <= 35'(w_ths1 - w_tac1);
        end
    end

    // Stage 27: Jacobian transpose times force, products.
    logic signed [63:0] r_t0a, r_t0b, r_t1a, r_t1b, r_t1c, r_t2a, r_t2b, r_t2c;
    logic signed [34:0] r_pxf, r_pyf, r_pzf;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t0a <= 64'(r_j10) * 64'(r_sd[26].fy);
            r_t0b <= 64'(r_j20) * 64'(r_sd[26].fz);
            r_t1a <= 64'(r_j01) * 64'(r_sd[26].fx);
            r_t1b <= 64'(r_j11) * 64'(r_sd[26].fy);
            r_t1c <= 64'(r_j21) * 64'(r_sd[26].fz);
            r_t2a <= 64'(r_j02) * 64'(r_sd[26].fx);
            r_t2b <= 64'(r_j12) * 64'(r_sd[26].fy);
            r_t2c <= 64'(r_j22) * 64'(r_sd[26].fz);
            r_pxf <= r_px;
            r_pyf <= r_j20;
            r_pzf <= r_pz;
        end
    end

    // Stage 28: sums, rescale and saturation into the output register.
    logic [27:0] r_tq0, r_tq1, r_tq2;
    logic [17:0] r_fx, r_fy, r_fz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tq0 <= f_sat28(f_trunc(r_t0a + r_t0b, 30));
            r_tq1 <= f_sat28(f_trunc(r_t1a + r_t1b + r_t1c, 30));
            r_tq2 <= f_sat28(f_trunc(r_t2a + r_t2b + r_t2c, 30));
            r_fx  <= f_sat18(f_trunc(64'(r_pxf), 14));
            r_fy  <= f_sat18(f_trunc(64'(r_pyf), 14));
            r_fz  <= f_sat18(f_trunc(64'(r_pzf), 14));
        end
    end

    assign m_axis_tdata = {6'b0, r_fz, r_fy, r_fx, r_tq2, r_tq1, r_tq0};

    // Checks on the pipeline control and the register port.
    `LJT_ASSERT_NEXT(a_in_vld, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0])
    `LJT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(r_vld))
    `LJT_ASSERT_SAME(a_rdy, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `LJT_ASSERT_NEXT(a_cfg, i_clk, i_rst_n, i_cfg_valid && i_cfg_index == CFG_HIP, r_hip_len == $past(i_cfg_data))

endmodule

`default_nettype wire

// ----- tb/leg_jacobian_transpose_torque_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leg Jacobian-transpose torque testbench
// Drives joint angles, leg indexes and foot forces into the unit through
// several link-length settings. Every result is compared field by field with
// a typed value or a fixed-point model of the leg kinematics in the bench.
// ----------------------------------------------------------------------------
module leg_jacobian_transpose_torque_tb;
    import ljt_pkg::*;

    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint QUART_PI = 64'sd843314856;
    localparam int     LATENCY  = 29;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     RANDOM_PER_PHASE = 280;

    // Sender and receiver idling modes.
    typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} t_idle;

    // One row of the directed table.
    typedef struct {
        logic [1:0]   leg;
        logic [15:0]  ang [3];
        logic [23:0]  frc [3];
        bit           typed;
        logic [143:0] result;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    // Bench copy of the link lengths, unsigned Q0.16.
    logic [15:0]  len_hip, len_thigh, len_calf;
    logic [143:0] pending_results [$];
    t_idle        idle_mode = IDLE_NONE;
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycles = 0;
    int           settings_used = 0;

    leg_jacobian_transpose_torque dut (.*);

    always #5 i_clk = ~i_clk;

    // Product of two Q30 values back in Q30, truncated toward zero.
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) / ONE_Q30;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Sine and cosine in Q30 of a Q3.13 angle, by quadrant reduction and series.
    task automatic angle_trig(input logic signed [15:0] a, output longint sn, output longint cs);
        longint r, x2, t, s, c;
        int quad;
        r = longint'(a) * 131072;
        quad = 0;
        while (r > QUART_PI) begin
            r -= HALF_PI;
            quad++;
        end
        while (r < -QUART_PI) begin
            r += HALF_PI;
            quad--;
        end
        x2 = q30_mul(r, r);
        t = r;
        s = r;
        for (int k = 1; k <= 6; k++) begin
            t = -q30_mul(t, x2) / longint'((2 * k) * (2 * k + 1));
            s += t;
        end
        t = ONE_Q30;
        c = ONE_Q30;
        for (int k = 1; k <= 6; k++) begin
            t = -q30_mul(t, x2) / longint'((2 * k - 1) * (2 * k));
            c += t;
        end
        case (quad & 3)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    // Joint torques and foot position of one leg, packed as on the output bus.
    task automatic leg_torques(input logic [1:0] leg, input logic [15:0] ang [3],
                               input logic [23:0] frc [3], output logic [143:0] res);
        longint s1, c1, s2, c2, s3, c3, s23, c23, h, l2, l3, a, b, c, d;
        longint j10, j20, j11, j21, j12, j22, fx, fy, fz;
        logic [27:0] tq0, tq1, tq2;
        logic [17:0] px, py, pz;
        angle_trig(ang[0], s1, c1);
        angle_trig(ang[1], s2, c2);
        angle_trig(ang[2], s3, c3);
        fx = longint'(signed'(frc[0]));
        fy = longint'(signed'(frc[1]));
        fz = longint'(signed'(frc[2]));
        l2 = longint'(len_thigh);
        l3 = longint'(len_calf);
        h = longint'(len_hip) * 16384;
        // Legs 0 and 2 sit on the negative side.
        if (!leg[0]) h = -h;
        c23 = (c2 * c3 - s2 * s3) / ONE_Q30;
        s23 = (s2 * c3 + c2 * s3) / ONE_Q30;
        a = (l2 * c2 + l3 * c23) / 65536;
        b = (l2 * s2 + l3 * s23) / 65536;
        c = (l3 * c23) / 65536;
        d = (l3 * s23) / 65536;
        j10 = -q30_mul(h, s1) + q30_mul(a, c1);
        j20 = q30_mul(h, c1) + q30_mul(a, s1);
        j11 = -q30_mul(b, s1);
        j21 = q30_mul(b, c1);
        j12 = -q30_mul(d, s1);
        j22 = q30_mul(d, c1);
        tq0 = 28'(clamp((j10 * fy + j20 * fz) / ONE_Q30, 28));
        tq1 = 28'(clamp((-a * fx + j11 * fy + j21 * fz) / ONE_Q30, 28));
        tq2 = 28'(clamp((-c * fx + j12 * fy + j22 * fz) / ONE_Q30, 28));
        px = 18'(clamp(-b / 16384, 18));
        py = 18'(clamp(j20 / 16384, 18));
        pz = 18'(clamp((q30_mul(h, s1) - q30_mul(a, c1)) / 16384, 18));
        res = {6'd0, pz, py, px, tq2, tq1, tq0};
    endtask

    // Register write through the configuration channel.
    task automatic write_length(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HIP:   len_hip = val;
            CFG_THIGH: len_thigh = val;
            CFG_CALF:  len_calf = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one request, idling beforehand as the current mode asks.
    task automatic send_leg(input logic [1:0] leg, input logic [15:0] ang [3],
                            input logic [23:0] frc [3], input bit typed,
                            input logic [143:0] typed_res);
        logic [143:0] res;
        int idle_pct;
        idle_pct = idle_mode == IDLE_SEND_LIGHT ? 26 : (idle_mode == IDLE_SEND_HEAVY ? 61 : 0);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        if (typed) res = typed_res;
        else leg_torques(leg, ang, frc, res);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= leg;
        s_axis_tdata <= {frc[2], frc[1], frc[0], ang[2], ang[1], ang[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(res);
    endtask

    // Hold off until every expected result is back and the pipeline is empty.
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    // Receiver readiness, changed at the falling edge.
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_SEND_LIGHT) m_axis_tready <= $urandom_range(99, 0) >= 61;
        else if (idle_mode == IDLE_SEND_HEAVY) m_axis_tready <= $urandom_range(99, 0) >= 26;
        else m_axis_tready <= 1'b1;
    end

    // Result checker, field by field against the oldest expectation.
    always @(posedge i_clk) begin
        logic [143:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                for (int f = 0; f < 6; f++) begin
                    logic [27:0] w, g;
                    w = f < 3 ? want[f*28 +: 28] : 28'(want[84 + (f-3)*18 +: 18]);
                    g = f < 3 ? m_axis_tdata[f*28 +: 28] : 28'(m_axis_tdata[84 + (f-3)*18 +: 18]);
                    if (w !== g) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d field %0d: expected %h, got %h",
                                     results_seen, f, w, g);
                    end
                end
            end
        end
    end

    // Cycle counter with a generous run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_row rows [$];
        t_row r;
        logic [15:0] ang [3];
        logic [23:0] frc [3];
        int sel;
        len_hip = HIP_RST;
        len_thigh = THIGH_RST;
        len_calf = CALF_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero pose and zero force: foot straight below, hip offset by side.
        for (int l = 0; l < 4; l++) begin
            r.leg = 2'(l);
            r.ang = '{16'd0, 16'd0, 16'd0};
            r.frc = '{24'd0, 24'd0, 24'd0};
            r.typed = 1'b1;
            r.result = {6'd0, 18'(-27918), (l[0] ? 18'(5243) : 18'(-5243)), 18'd0, 84'd0};
            rows.push_back(r);
        end
        // Force and angle extremes, around the quarter-turn bound and beyond pi.
        r.typed = 1'b0;
        r.result = '0;
        r.leg = 2'd1;
        r.ang = '{16'd0, 16'd0, 16'd0};
        r.frc = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
        rows.push_back(r);
        r.leg = 2'd2;
        r.frc = '{24'h800000, 24'h800000, 24'h800000};
        rows.push_back(r);
        r.leg = 2'd3;
        r.ang = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        r.frc = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF};
        rows.push_back(r);
        r.leg = 2'd0;
        r.ang = '{16'h8000, 16'h8000, 16'h8000};
        r.frc = '{24'h800000, 24'h7FFFFF, 24'h800000};
        rows.push_back(r);
        r.ang = '{16'd6433, 16'd6434, -16'sd6434};
        r.frc = '{24'd2560, 24'd2560, -24'sd2560};
        rows.push_back(r);
        r.leg = 2'd1;
        r.ang = '{16'd25736, -16'sd25736, 16'd12868};
        rows.push_back(r);
        r.ang = '{16'd12868, 16'd12868, -16'sd12868};
        r.frc = '{24'hFFFFFF, 24'd1, 24'h000100};
        rows.push_back(r);
        r.leg = 2'd3;
        r.ang = '{16'hFFFF, 16'h0001, 16'h5555};
        r.frc = '{24'h555555, 24'hAAAAAA, 24'h0F0F0F};
        rows.push_back(r);

        idle_mode = IDLE_NONE;
        foreach (rows[i]) send_leg(rows[i].leg, rows[i].ang, rows[i].frc,
                                   rows[i].typed, rows[i].result);
        drain();

        // Random phases, each under its own link lengths.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_length(CFG_HIP, HIP_RST); write_length(CFG_THIGH, THIGH_RST);
                         write_length(CFG_CALF, CALF_RST); end
                1: begin write_length(CFG_HIP, 16'hFFFF); write_length(CFG_THIGH, 16'hFFFF);
                         write_length(CFG_CALF, 16'hFFFF); end
                2: begin write_length(CFG_HIP, 16'h0000); write_length(CFG_THIGH, 16'h0000);
                         write_length(CFG_CALF, 16'h0000); end
                default: begin write_length(CFG_HIP, 16'($urandom));
                               write_length(CFG_THIGH, 16'($urandom));
                               write_length(CFG_CALF, 16'($urandom)); end
            endcase
            // An index past the register list must leave the lengths alone.
            write_length(2'd3, 16'($urandom));
            settings_used++;
            idle_mode = p < 2 ? IDLE_SEND_LIGHT : (p < 4 ? IDLE_SEND_HEAVY : IDLE_NONE);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                for (int k = 0; k < 3; k++) begin
                    ang[k] = 16'($urandom);
                    sel = $urandom_range(9, 0);
                    if (sel == 0) frc[k] = 24'h7FFFFF;
                    else if (sel == 1) frc[k] = 24'h800000;
                    else if (sel == 2) frc[k] = 24'($signed($urandom_range(2000, 0)) - 1000);
                    else frc[k] = 24'($urandom);
                end
                send_leg(2'($urandom_range(3, 0)), ang, frc, 1'b0, '0);
            end
            drain();
        end

        $display("Covered %0d results over %0d link-length settings plus the reset values,",
                 results_seen, settings_used);
        $display("with three idling patterns on both sides and %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
